// ----- hw/rtl/fgr_pkg.sv -----
// Shared constants and types of the fraction reducer.
`default_nettype none

package fgr_pkg;

    // Default width of the numerator and denominator inputs.
    localparam int DEFAULT_VALUE_WIDTH = 16;

    // Fixed width of the reduced numerator and denominator outputs.
    localparam int OUT_WIDTH = 16;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GCD  = 4'b0010,
        S_DIVN = 4'b0100,
        S_DIVD = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fgr_divider.sv -----
// Serial restoring divider that gives one quotient bit per cycle.
`default_nettype none

module fgr_divider
    import fgr_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [VALUE_WIDTH-1:0] divisor,
    output logic                        done,
    output logic [VALUE_WIDTH-1:0]      quotient,
    output logic [VALUE_WIDTH-1:0]      remainder
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign trial = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_WIDTH);
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            quot_next = {quot_reg[VALUE_WIDTH-2:0], ge};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fraction_gcd_reducer.sv -----
// Top level of the fraction reducer: Euclid sequencer around a shared serial divider.
//
//   Channel   Ports                                        Handshake
//   -------   ------------------------------------------   ----------------------------
//   input     numerator, denominator                       start high while busy is low
//   result    reduced_numerator, reduced_denominator,      done high for one cycle
//             scaling_active, invalid_input
//
// A valid item takes S + 2 divisions, where S is the number of Euclid remainder steps
// (at most 23 at 16 bits); each division runs one quotient bit per cycle on the single
// shared divider, so that divider sets the rate, and a new item waits until busy is low.
// An item with a zero input gives its result in the next cycle and never uses the divider.
// Reset is asynchronous and active low; it returns the sequencer to idle.
// The receiver cannot stall: done marks the result for exactly one cycle.
`default_nettype none

module fraction_gcd_reducer
    import fgr_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [VALUE_WIDTH-1:0] numerator,
    input  wire logic [VALUE_WIDTH-1:0] denominator,
    output logic                        done,
    output logic [OUT_WIDTH-1:0]        reduced_numerator,
    output logic [OUT_WIDTH-1:0]        reduced_denominator,
    output logic                        scaling_active,
    output logic                        invalid_input
);

    localparam int EW = OUT_WIDTH + VALUE_WIDTH;

    state_t                 state_reg, state_next;
    logic                   launch_reg, launch_next;
    logic                   done_reg, done_next;

    // Working values: x and y hold the Euclid pair; x holds the divisor at the end.
    logic [VALUE_WIDTH-1:0] x_reg, x_next;
    logic [VALUE_WIDTH-1:0] y_reg, y_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH-1:0] qn_reg, qn_next;

    logic [OUT_WIDTH-1:0]   rn_reg, rn_next;
    logic [OUT_WIDTH-1:0]   rd_reg, rd_next;
    logic                   scale_reg, scale_next;
    logic                   inval_reg, inval_next;

    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_divisor;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [VALUE_WIDTH-1:0] div_rem;

    logic [EW-1:0]          qn_ext;
    logic [EW-1:0]          qd_ext;

    // The one divider serves the Euclid steps and both final divisions.
    fgr_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (launch_reg),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Operand selection follows the phase of the sequencer.
    always_comb
    begin
        unique case (state_reg)
            S_GCD:
            begin
                div_dividend = x_reg;
                div_divisor  = y_reg;
            end
            S_DIVN:
            begin
                div_dividend = n_reg;
                div_divisor  = x_reg;
            end
            S_DIVD:
            begin
                div_dividend = d_reg;
                div_divisor  = x_reg;
            end
            default:
            begin
                div_dividend = x_reg;
                div_divisor  = y_reg;
            end
        endcase
    end

    // The outputs are a fixed width; the quotients are cut or widened to fit.
    assign qn_ext = {{OUT_WIDTH{1'b0}}, qn_reg};
    assign qd_ext = {{OUT_WIDTH{1'b0}}, div_quot};

    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        done_next   = 1'b0;
        x_next      = x_reg;
        y_next      = y_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        qn_next     = qn_reg;
        rn_next     = rn_reg;
        rd_next     = rd_reg;
        scale_next  = scale_reg;
        inval_next  = inval_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (numerator == '0 || denominator == '0)
                    begin
                        // A zero operand makes the pair invalid: answer 1/1 at once.
                        rn_next    = OUT_WIDTH'(1);
                        rd_next    = OUT_WIDTH'(1);
                        scale_next = 1'b0;
                        inval_next = 1'b1;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        x_next      = numerator;
                        y_next      = denominator;
                        n_next      = numerator;
                        d_next      = denominator;
                        launch_next = 1'b1;
                        state_next  = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                if (div_done)
                begin
                    // Euclid step: (x, y) becomes (y, x mod y).
                    x_next      = y_reg;
                    y_next      = div_rem;
                    launch_next = 1'b1;
                    if (div_rem == '0)
                    begin
                        state_next = S_DIVN;
                    end
                end
            end
            S_DIVN:
            begin
                if (div_done)
                begin
                    qn_next     = div_quot;
                    launch_next = 1'b1;
                    state_next  = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_done)
                begin
                    rn_next    = qn_ext[OUT_WIDTH-1:0];
                    rd_next    = qd_ext[OUT_WIDTH-1:0];
                    scale_next = (qn_reg != VALUE_WIDTH'(1)) || (div_quot != VALUE_WIDTH'(1));
                    inval_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        qn_reg    <= qn_next;
        rn_reg    <= rn_next;
        rd_reg    <= rd_next;
        scale_reg <= scale_next;
        inval_reg <= inval_next;
    end

    assign busy                = (state_reg != S_IDLE);
    assign done                = done_reg;
    assign reduced_numerator   = rn_reg;
    assign reduced_denominator = rd_reg;
    assign scaling_active      = scale_reg;
    assign invalid_input       = inval_reg;

    // An accepted item either answers at once (invalid) or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted item neither started nor answered");

    // An invalid result is always 1/1 with scaling off.
    a_invalid_unity: assert property (@(posedge clk) disable iff (!rst_n)
        done && invalid_input |-> reduced_numerator == OUT_WIDTH'(1)
            && reduced_denominator == OUT_WIDTH'(1) && !scaling_active)
        else $error("invalid result is not 1/1");

    // The divider only finishes while the sequencer is waiting for it.
    a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> busy)
        else $error("divider finished while idle");

endmodule

`default_nettype wire

// ----- bench/fraction_gcd_reducer_test.sv -----
// Self-checking testbench for the Euclid-based fraction reducer.
`timescale 1ns / 100ps

module fraction_gcd_reducer_test;
    import fgr_pkg::*;

    // The block is built at its default width, so every port bit is exercised.
    localparam int VW = DEFAULT_VALUE_WIDTH;

    // Per-item worst case is about 25 divisions on the serial divider, and sender pauses
    // add to that. The cycle limit allows several times the slowest correct run of
    // roughly 800 items.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int MAX_PRINTED = 40;

    // One reduced fraction, as the result ports carry it.
    typedef struct packed {
        logic [OUT_WIDTH-1:0] num;
        logic [OUT_WIDTH-1:0] den;
        logic                 scaled;
        logic                 invalid;
    } fraction_result_t;

    // Keeps the reduced fractions still owed by the block, in order of acceptance,
    // and compares each strobed result against the oldest of them.
    class fraction_scoreboard;
        fraction_result_t owed_fractions[$];
        int failures;

        function new();
            failures = 0;
        endfunction

        // Reduces n/d by Euclid's method. A zero on either side marks the pair invalid
        // and forces 1/1.
        function fraction_result_t reduce_fraction(logic [VW-1:0] n, logic [VW-1:0] d);
            logic [VW-1:0] a;
            logic [VW-1:0] b;
            logic [VW-1:0] r;
            fraction_result_t res;
            if (n == '0 || d == '0) begin
                res.num = OUT_WIDTH'(1);
                res.den = OUT_WIDTH'(1);
                res.invalid = 1'b1;
            end else begin
                a = n;
                b = d;
                while (b != '0) begin
                    r = a % b;
                    a = b;
                    b = r;
                end
                res.num = OUT_WIDTH'(n / a);
                res.den = OUT_WIDTH'(d / a);
                res.invalid = 1'b0;
            end
            res.scaled = (res.num != OUT_WIDTH'(1) || res.den != OUT_WIDTH'(1));
            return res;
        endfunction

        function int pending();
            return owed_fractions.size();
        endfunction

        task report_mismatch(string what);
            if (failures < MAX_PRINTED)
                $display("%0d ns: mismatch: %s", $time, what);
            failures++;
        endtask

        function void note_item(logic [VW-1:0] n, logic [VW-1:0] d);
            owed_fractions.push_back(reduce_fraction(n, d));
        endfunction

        task check_result(fraction_result_t got);
            fraction_result_t want;
            string diffs;
            if (owed_fractions.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d/%0d scaled=%0b invalid=%0b",
                                          got.num, got.den, got.scaled, got.invalid));
            end else begin
                want = owed_fractions.pop_front();
                diffs = "";
                if (got.num !== want.num)
                    diffs = {diffs, $sformatf(" numerator %0d want %0d", got.num, want.num)};
                if (got.den !== want.den)
                    diffs = {diffs, $sformatf(" denominator %0d want %0d", got.den, want.den)};
                if (got.scaled !== want.scaled)
                    diffs = {diffs, $sformatf(" scaling_active %0b want %0b",
                                              got.scaled, want.scaled)};
                if (got.invalid !== want.invalid)
                    diffs = {diffs, $sformatf(" invalid_input %0b want %0b",
                                              got.invalid, want.invalid)};
                if (diffs != "")
                    report_mismatch(diffs);
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [VW-1:0]        numerator = '0;
    logic [VW-1:0]        denominator = '0;
    logic                 busy;
    logic                 done;
    logic [OUT_WIDTH-1:0] reduced_numerator;
    logic [OUT_WIDTH-1:0] reduced_denominator;
    logic                 scaling_active;
    logic                 invalid_input;

    fraction_scoreboard sb = new();

    // Percent chance that the sender pauses before presenting the next item.
    int idle_pct = 0;
    int cycle_count = 0;

    fraction_gcd_reducer #(
        .VALUE_WIDTH(VW)
    ) uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .numerator           (numerator),
        .denominator         (denominator),
        .done                (done),
        .reduced_numerator   (reduced_numerator),
        .reduced_denominator (reduced_denominator),
        .scaling_active      (scaling_active),
        .invalid_input       (invalid_input)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("fraction_gcd_reducer_test NOT OK");
                $finish;
            end
        end
    end

    // Result monitor. Outputs are sampled in the active region right after the edge,
    // so the values seen are those that the edge accepted. The receiver can never
    // stall, so every strobe is one result.
    always @(posedge clk)
    begin
        fraction_result_t got;
        if (rst_n && done)
        begin
            got.num = reduced_numerator;
            got.den = reduced_denominator;
            got.scaled = scaling_active;
            got.invalid = invalid_input;
            sb.check_result(got);
        end
    end

    // Presents one item and holds it until the block takes it. Start is only lowered
    // when the sender actually pauses, so back-to-back items keep start high.
    // Most pauses are short. Some run long enough to leave the block idle between items.
    task automatic send_fraction(input logic [VW-1:0] n, input logic [VW-1:0] d);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 600) : $urandom_range(1, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        numerator <= n;
        denominator <= d;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(n, d);
    endtask

    // Stops sending until every owed result has come back, then lets the block settle.
    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Draws one operand pair. Nearly a third of the pairs are built on a common factor
    // so that the reduction does work. Full-range draws toggle every input bit.
    // Zero and equal operands and consecutive Fibonacci numbers cover the invalid
    // case, the 1/1 case and the longest Euclid chains.
    task automatic pick_fraction(output logic [VW-1:0] n, output logic [VW-1:0] d);
        int fib[24];
        int k;
        int g;
        fib[0] = 1;
        fib[1] = 2;
        for (k = 2; k < 24; k++)
            fib[k] = fib[k-1] + fib[k-2];
        case ($urandom_range(99)) inside
            [0:34]:
            begin
                n = VW'($urandom);
                d = VW'($urandom);
            end
            [35:64]:
            begin
                g = $urandom_range(1, 400);
                n = VW'(g * $urandom_range(1, 65535 / g));
                d = VW'(g * $urandom_range(1, 65535 / g));
            end
            [65:79]:
            begin
                n = VW'($urandom_range(0, 24));
                d = VW'($urandom_range(0, 24));
            end
            [80:86]:
            begin
                k = $urandom_range(1, 22);
                n = VW'(fib[k]);
                d = VW'(fib[k-1]);
                if ($urandom_range(1))
                begin
                    n = VW'(fib[k-1]);
                    d = VW'(fib[k]);
                end
            end
            [87:91]:
            begin
                n = VW'($urandom_range(1, 65535));
                d = n;
            end
            [92:95]:
            begin
                n = $urandom_range(1) ? '0 : VW'($urandom);
                d = (n == '0) ? VW'($urandom) : '0;
            end
            default:
            begin
                n = $urandom_range(1) ? '1 : VW'(1);
                d = VW'($urandom);
            end
        endcase
    endtask

    initial
    begin
        logic [VW-1:0] n;
        logic [VW-1:0] d;
        int phase_idle[3];
        int p;
        int i;

        // Reset is held low from the start of the run and released once.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: zero operands, extremes, equal values, a Fibonacci worst case,
        // and alternating bit patterns.
        send_fraction(16'd0, 16'd0);
        send_fraction(16'd0, 16'd5);
        send_fraction(16'd7, 16'd0);
        send_fraction(16'd0, 16'hFFFF);
        send_fraction(16'hFFFF, 16'd0);
        send_fraction(16'd1, 16'd1);
        send_fraction(16'hFFFF, 16'hFFFF);
        send_fraction(16'hFFFF, 16'd1);
        send_fraction(16'd1, 16'hFFFF);
        send_fraction(16'd12345, 16'd12345);
        send_fraction(16'd46368, 16'd28657);
        send_fraction(16'd28657, 16'd46368);
        send_fraction(16'h8000, 16'hFFFF);
        send_fraction(16'd65534, 16'd32767);
        send_fraction(16'd100, 16'd250);
        send_fraction(16'hFFFF, 16'd21845);
        send_fraction(16'hAAAA, 16'h5555);
        send_fraction(16'h5555, 16'hAAAA);
        send_fraction(16'd1, 16'd2);
        send_fraction(16'd4096, 16'd64);
        send_fraction(16'd100, 16'd100);
        drain_results();

        // Random phases: a steady sender, one that is mostly idle, and one that idles
        // now and then. Each phase is drained before the next begins, so the sender
        // also waits out every owed result at least once.
        phase_idle[0] = 0;
        phase_idle[1] = 85;
        phase_idle[2] = 35;
        for (p = 0; p < 3; p++)
        begin
            idle_pct = phase_idle[p];
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                pick_fraction(n, d);
                send_fraction(n, d);
            end
            drain_results();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("fraction_gcd_reducer_test OK");
        else
            $display("fraction_gcd_reducer_test NOT OK");
        $finish;
    end

endmodule

// ----- fraction_gcd_reducer.f -----
hw/rtl/fgr_pkg.sv
hw/rtl/fgr_divider.sv
hw/rtl/fraction_gcd_reducer.sv
bench/fraction_gcd_reducer_test.sv
